// File: rtl/qphi_pkg.sv
// Shared constants and controller/datapath interface types for the hash insert block.
`default_nettype none

package qphi_pkg;

    // Fixed field widths of the block's ports.
    localparam int SLOT_W = 10;
    localparam int CFG_W  = 11;

    // Default sizing of the table and of the key.
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 31;

    // Table size minimum and reset value.
    localparam int SIZE_MIN   = 2;
    localparam int SIZE_RESET = 2;

    // Key bits consumed by the remainder unit in each cycle.
    localparam int DIV_STEP_BITS = 4;

    // Odd probe offsets grow by this much per collision.
    localparam int STEP_INC = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic probe_init;
        logic mem_rd;
        logic advance;
        logic store;
        logic fail;
        logic clr;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic clr_last;
        logic hit;
        logic full_next;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/qphi_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module qphi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Per cycle a write, a registered read, or both at one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/qphi_dp.sv
// Datapath: size register, remainder unit, probe arithmetic, table memory and result registers.
`default_nettype none

module qphi_dp
    import qphi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output logic                      o_done,
    output logic [SLOT_W-1:0]         o_slot,
    output logic                      o_full_res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SZ_W  = IDX_W + 1;
    localparam int CMP_W = (SZ_W > CFG_W) ? SZ_W : CFG_W;
    localparam int NDIV  = (KEY_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int KP    = NDIV * DIV_STEP_BITS;
    localparam int DC_W  = $clog2(NDIV);
    localparam int OUT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int MEM_W = KEY_WIDTH + 1;

    // Effective table size, clamped into range when written.
    logic [SZ_W-1:0]  r_size;
    logic [SZ_W-1:0]  n_size;
    logic [CMP_W-1:0] cfg_ext;

    always_comb begin
        cfg_ext = CMP_W'(i_cfg_data);
        if (cfg_ext < CMP_W'(SIZE_MIN)) begin
            n_size = SZ_W'(SIZE_MIN);
        end else if (cfg_ext > CMP_W'(TABLE_DEPTH)) begin
            n_size = SZ_W'(TABLE_DEPTH);
        end else begin
            n_size = cfg_ext[SZ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SZ_W'(SIZE_RESET);
        end else if (i_cfg_we) begin
            r_size <= n_size;
        end
    end

    // Remainder unit: restoring reduction, several key bits per cycle, MSB first.
    logic [KEY_WIDTH-1:0] r_key;
    logic [KP-1:0]        r_kq;
    logic [SZ_W-1:0]      r_rem;
    logic [DC_W-1:0]      r_div_cnt;
    logic [SZ_W:0]        div_t;
    logic [SZ_W-1:0]      n_rem;

    always_comb begin
        n_rem = r_rem;
        div_t = '0;
        for (int j = 0; j < DIV_STEP_BITS; j++) begin
            div_t = {n_rem, r_kq[KP-1-j]};
            if (div_t >= {1'b0, r_size}) begin
                div_t = div_t - {1'b0, r_size};
            end
            n_rem = div_t[SZ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_key;
            r_kq      <= KP'(i_key);
            r_rem     <= '0;
            r_div_cnt <= DC_W'(NDIV - 1);
        end else if (i_cmd.div_step) begin
            r_kq      <= r_kq << DIV_STEP_BITS;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    assign o_sts.div_last = (r_div_cnt == '0);

    // Probe state: position, home slot, current odd offset modulo size, collision count.
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_home;
    logic [IDX_W-1:0] r_step;
    logic [SZ_W-1:0]  r_k;
    logic [SZ_W:0]    step_sum;
    logic [SZ_W:0]    pos_sum;
    logic [IDX_W-1:0] n_step;
    logic [IDX_W-1:0] n_pos;
    logic [SZ_W-1:0]  n_k;

    // Next offset is the previous one plus two, then the position moves by it.
    always_comb begin
        step_sum = (SZ_W+1)'(r_step) + (SZ_W+1)'(STEP_INC);
        if (step_sum >= {1'b0, r_size}) begin
            step_sum = step_sum - {1'b0, r_size};
        end
        n_step  = step_sum[IDX_W-1:0];
        pos_sum = (SZ_W+1)'(r_pos) + (SZ_W+1)'(n_step);
        if (pos_sum >= {1'b0, r_size}) begin
            pos_sum = pos_sum - {1'b0, r_size};
        end
        n_pos = pos_sum[IDX_W-1:0];
        n_k   = r_k + 1'b1;
    end

    assign o_sts.full_next = (n_pos == r_home) || (n_k >= r_size);

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_pos  <= r_rem[IDX_W-1:0];
            r_home <= r_rem[IDX_W-1:0];
            r_step <= IDX_W'(r_size - 1'b1);
            r_k    <= '0;
        end else if (i_cmd.advance) begin
            r_pos  <= n_pos;
            r_step <= n_step;
            r_k    <= n_k;
        end
    end

    // Clearing pass address after reset.
    logic [IDX_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == IDX_W'(TABLE_DEPTH - 1));

    // Table memory: each word holds a used flag above the stored key.
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [MEM_W-1:0] mem_wdata;
    logic [MEM_W-1:0] mem_rdata;

    assign mem_we    = i_cmd.store || i_cmd.clr;
    assign mem_addr  = i_cmd.clr ? r_clr_addr : r_pos;
    assign mem_wdata = i_cmd.clr ? '0 : {1'b1, r_key};

    qphi_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (i_cmd.mem_rd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // A slot is usable when it is empty or already holds this key.
    assign o_sts.hit = !mem_rdata[KEY_WIDTH] || (mem_rdata[KEY_WIDTH-1:0] == r_key);

    // Result registers: one beat per item.
    logic             r_done;
    logic [SLOT_W-1:0] r_slot;
    logic             r_full;
    logic [OUT_W-1:0] pos_ext;

    assign pos_ext = OUT_W'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.store || i_cmd.fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_slot <= pos_ext[SLOT_W-1:0];
            r_full <= 1'b0;
        end else if (i_cmd.fail) begin
            r_slot <= '0;
            r_full <= 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_slot     = r_slot;
    assign o_full_res = r_full;

endmodule

`default_nettype wire

// File: rtl/qphi_ctrl.sv
// Controller state machine: clearing pass, remainder, probe walk and result.
`default_nettype none

module qphi_ctrl
    import qphi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.probe_init = 1'b1;
                n_state          = S_READ;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.full_next) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/quadratic_probe_hash_insert.sv
// Top level of the open-addressing hash table insert with quadratic probing.
//
//   Channel  | Ports                        | Handshake
//   ---------+------------------------------+------------------------------------
//   key in   | i_key                        | beat taken when start && !busy
//   result   | o_slot, o_full_res           | o_done high for one cycle, no stall
//   config   | i_cfg_data                   | written when i_cfg_we is high
//
// After reset the table memory is cleared one slot a cycle, through every slot,
// with busy high; configuration writes are taken during that time.
// An item is loaded, reduced in the remainder unit and set up for probing; each
// probe is a memory read, then a compare, until a slot is usable or the walk
// ends with the table full, and the result beat is registered after the compare.
// The remainder unit and the probe walk through the single memory port set how long an item takes.
// The receiver cannot stall; busy drops in the cycle the result beat appears.
`default_nettype none

module quadratic_probe_hash_insert
    import qphi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_done,
    output logic [SLOT_W-1:0]         o_slot,
    output logic                      o_full_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller.
    qphi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath.
    qphi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_key      (i_key),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_done     (o_done),
        .o_slot     (o_slot),
        .o_full_res (o_full_res)
    );

`ifndef SYNTHESIS
    // A full report never carries a slot number.
    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_full_res) |-> (o_slot == '0))
        else $error("full result with nonzero slot");

    // Result beats never come back to back.
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    // A result only follows a cycle in which the block was busy.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without work in progress");

    // The clearing pass never shares the memory port with a key write or a probe read.
    a_no_clr_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clr && (cmd.store || cmd.mem_rd)))
        else $error("memory port conflict during clearing pass");

    // An accepted key makes the block busy in the following cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted key did not make the block busy");
`endif

endmodule

`default_nettype wire
